// ===== rtl/mlqs_pkg.sv =====
// Shared types and codes for the multilevel queue scheduler.
`timescale 1ns / 1ps

package mlqs_pkg;

  localparam int ID_W     = 6;
  localparam int PRIO_W   = 3;
  localparam int STATUS_W = 2;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_PICK    = 1'b1;

  localparam logic [STATUS_W-1:0] ST_ENQUEUED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PICKED   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE     = 2'd2;

  typedef struct packed {
    logic              opcode;
    logic [ID_W-1:0]   task_id;
    logic [PRIO_W-1:0] priority_req;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     picked_task;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic advance;
  } ctrl_cmd_t;

  typedef struct packed {
    logic needs_link;
  } dp_status_t;

endpackage

// ===== rtl/mlqs_ctrl.sv =====
// Control state machine and output valid flag for the scheduler.
`timescale 1ns / 1ps

module mlqs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output mlqs_pkg::ctrl_cmd_t cmd,
  input  mlqs_pkg::dp_status_t stat
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_LINK = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   out_valid_next;
  logic   accept;
  logic   slot_free;
  logic   exec;

  // New items enter while idle or while the head update finishes.
  assign req_ready = !rst && ((state == S_IDLE) || (state == S_LINK));
  assign accept    = req_valid && req_ready;
  assign slot_free = !out_valid || rsp_ready;
  assign exec      = (state == S_EXEC) && slot_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (slot_free) state_next = stat.needs_link ? S_LINK : S_IDLE;
      end
      S_LINK: begin
        state_next = accept ? S_EXEC : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (exec) begin
      out_valid_next = 1'b1;
    end else if (rsp_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  assign cmd.load    = accept;
  assign cmd.exec    = exec;
  assign cmd.advance = (state == S_LINK);
  assign rsp_valid   = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_link_after_exec: assert property (@(posedge clk) disable iff (rst)
    state == S_LINK |-> $past(state == S_EXEC))
    else $error("head update without a preceding pick");

  a_rsp_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EXEC))
    else $error("result raised outside execution");

endmodule

// ===== rtl/mlqs_dp.sv =====
// Queue datapath: level bits, head and tail pointers, link table, result register.
`timescale 1ns / 1ps

module mlqs_dp #(
  parameter int NUM_LEVELS = 8,
  parameter int MAX_TASKS  = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mlqs_pkg::req_t       req,
  input  mlqs_pkg::ctrl_cmd_t  cmd,
  output mlqs_pkg::dp_status_t stat,
  output mlqs_pkg::rsp_t       rsp
);

  localparam int LVL_W  = $clog2(NUM_LEVELS);
  localparam int TASK_W = $clog2(MAX_TASKS);
  localparam int ID_W   = mlqs_pkg::ID_W;

  mlqs_pkg::req_t item;
  mlqs_pkg::rsp_t rsp_q;
  mlqs_pkg::rsp_t rsp_next;

  logic [NUM_LEVELS-1:0] level_nonempty;
  logic [ID_W-1:0]       queue_head [NUM_LEVELS];
  logic [ID_W-1:0]       queue_tail [NUM_LEVELS];
  logic [ID_W-1:0]       link_table [MAX_TASKS];
  logic [ID_W-1:0]       link_rdata;
  logic [LVL_W-1:0]      sel_q;

  logic              is_pick;
  logic              id_ok;
  logic [LVL_W-1:0]  enq_lvl;
  logic [ID_W-1:0]   enq_tail;
  logic              enq_bit_set;
  logic              found;
  logic [LVL_W-1:0]  pick_lvl;
  logic [ID_W-1:0]   head_h;
  logic              single;
  logic              link_we;
  logic [TASK_W-1:0] link_waddr;
  logic [TASK_W-1:0] link_raddr;

  assign is_pick = (item.opcode == mlqs_pkg::OP_PICK);
  assign id_ok   = (int'(item.task_id) < MAX_TASKS);

  // Saturate out-of-range priorities to the lowest level.
  always_comb begin
    if (int'(item.priority_req) >= NUM_LEVELS) begin
      enq_lvl = LVL_W'(NUM_LEVELS - 1);
    end else begin
      enq_lvl = LVL_W'(item.priority_req);
    end
  end

  // Highest-priority nonempty level; lowest index wins.
  always_comb begin
    found    = 1'b0;
    pick_lvl = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (level_nonempty[i]) begin
        found    = 1'b1;
        pick_lvl = LVL_W'(i);
      end
    end
  end

  assign enq_tail    = queue_tail[enq_lvl];
  assign enq_bit_set = level_nonempty[enq_lvl];
  assign head_h      = queue_head[pick_lvl];
  assign single      = (head_h == queue_tail[pick_lvl]);

  assign stat.needs_link = is_pick && found && !single;

  assign link_we    = cmd.exec && !is_pick && id_ok && enq_bit_set;
  assign link_waddr = TASK_W'(enq_tail);
  assign link_raddr = TASK_W'(head_h);

  always_comb begin
    if (!is_pick) begin
      rsp_next.status      = mlqs_pkg::ST_ENQUEUED;
      rsp_next.picked_task = '0;
    end else if (found) begin
      rsp_next.status      = mlqs_pkg::ST_PICKED;
      rsp_next.picked_task = head_h;
    end else begin
      rsp_next.status      = mlqs_pkg::ST_NONE;
      rsp_next.picked_task = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) link_table[link_waddr] <= item.task_id;
    link_rdata <= link_table[link_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item <= req;
    if (cmd.exec) begin
      rsp_q <= rsp_next;
      sel_q <= pick_lvl;
      if (!is_pick && id_ok) begin
        if (!enq_bit_set) queue_head[enq_lvl] <= item.task_id;
        queue_tail[enq_lvl] <= item.task_id;
      end
    end
    // Advance the head to the successor read during the pick.
    if (cmd.advance) queue_head[sel_q] <= link_rdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_nonempty <= '0;
    end else if (cmd.exec) begin
      if (!is_pick && id_ok) begin
        level_nonempty[enq_lvl] <= 1'b1;
      end else if (is_pick && found && single) begin
        level_nonempty[pick_lvl] <= 1'b0;
      end
    end
  end

  assign rsp = rsp_q;

  a_adv_level_live: assert property (@(posedge clk) disable iff (rst)
    cmd.advance |-> level_nonempty[sel_q])
    else $error("head advanced on an empty level");

  a_enq_sets_level: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && !is_pick && id_ok |=> level_nonempty[$past(enq_lvl)])
    else $error("enqueue left its level empty");

endmodule

// ===== rtl/multilevel_queue_scheduler.sv =====
// Top level of the multilevel priority queue scheduler.
//
// Request channel (req_valid/req_ready/req): opcode 0 enqueues task_id at
// level priority_req (0 highest, levels past the last one saturate to it;
// ids at or beyond MAX_TASKS are dropped). Opcode 1 picks the head task of
// the highest-priority nonempty level.
// Response channel (rsp_valid/rsp_ready/rsp): one item per request, status
// enqueued, picked (with picked_task) or no task ready.
// The request is registered, then executes into the output register once
// that register is free; no new request is taken while one executes. A
// pick that leaves its level nonempty then waits in a head update on the
// registered link table read that yields the new head of the level.
// Reset clears every level to empty; head, tail and link storage need no
// clearing, so items are taken right after reset.
// If the receiver stalls, the finished item holds in the output register,
// one more request is taken and waits until the output register frees.
`timescale 1ns / 1ps

module multilevel_queue_scheduler #(
  parameter int NUM_LEVELS = 8,
  parameter int MAX_TASKS  = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  mlqs_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output mlqs_pkg::rsp_t rsp
);

  mlqs_pkg::ctrl_cmd_t  cmd;
  mlqs_pkg::dp_status_t stat;

  mlqs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  mlqs_dp #(
    .NUM_LEVELS (NUM_LEVELS),
    .MAX_TASKS  (MAX_TASKS)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .stat (stat),
    .rsp  (rsp)
  );

endmodule
